// ----- rtl/core/gcd_pkg.sv -----
package gcd_pkg;

    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30      = 34'sh040000000;
    localparam logic [31:0]        TWO_PI_Q29   = 32'd3373259426;
    localparam logic [26:0]        DIST_MAX     = 27'd67108863;
    localparam logic [23:0]        RADIUS_RESET = 24'd880657;
    localparam logic [6:0]         DEG_DIVISOR  = 7'd45;
    localparam logic [39:0]        ROUND_BIAS   = 40'd22;
    localparam logic [31:0]        HALF_TURN    = 32'h80000000;
    localparam int                 DIV_STAGES   = 5;
    localparam int                 DIV_BITS     = 8;
    localparam int                 SQRT_STEPS   = 31;
    localparam int                 LANES        = 4;

    typedef struct packed {
        logic [39:0] num;
        logic [5:0]  rem;
        logic        neg;
    } div_lane_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic [1:0]         quad;
    } rot_lane_t;

    typedef struct packed {
        logic [61:0] arg;
        logic [34:0] rem;
        logic [30:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } vec_lane_t;

    function automatic logic [29:0] atan_bam(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'h20000000;
            5'd1:  r = 30'h12E4051D;
            5'd2:  r = 30'h09FB385B;
            5'd3:  r = 30'h051111D4;
            5'd4:  r = 30'h028B0D43;
            5'd5:  r = 30'h0145D7E1;
            5'd6:  r = 30'h00A2F61E;
            5'd7:  r = 30'h00517C55;
            5'd8:  r = 30'h0028BE53;
            5'd9:  r = 30'h00145F2E;
            5'd10: r = 30'h000A2F98;
            5'd11: r = 30'h000517CC;
            5'd12: r = 30'h00028BE6;
            5'd13: r = 30'h000145F3;
            5'd14: r = 30'h0000A2F9;
            5'd15: r = 30'h0000517C;
            5'd16: r = 30'h000028BE;
            5'd17: r = 30'h0000145F;
            5'd18: r = 30'h00000A2F;
            5'd19: r = 30'h00000517;
            5'd20: r = 30'h0000028B;
            5'd21: r = 30'h00000145;
            5'd22: r = 30'h000000A2;
            5'd23: r = 30'h00000051;
            5'd24: r = 30'h00000028;
            5'd25: r = 30'h00000014;
            5'd26: r = 30'h0000000A;
            5'd27: r = 30'h00000005;
            5'd28: r = 30'h00000002;
            5'd29: r = 30'h00000001;
            default: r = 30'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/great_circle_distance.sv -----
// Haversine great-circle distance, fully pipelined: one word is accepted per cycle while
// in_stall is low. The depth is set by the degree to binary-angle divider, the rotation
// CORDIC, the two 31-step square roots and the vectoring CORDIC, one CORDIC or root step
// per register stage. A stall on the output while a result waits there freezes the whole
// pipeline; the radius register should only be written while no word is in flight.
module great_circle_distance #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [27:0] lat_first,
    input  logic signed [28:0] lon_first,
    input  logic signed [27:0] lat_second,
    input  logic signed [28:0] lon_second,
    input  logic               cfg_wr_en,
    input  logic [23:0]        cfg_wr_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [25:0]        distance_q8
);

    localparam int DS = gcd_pkg::DIV_STAGES;
    localparam int SQ = gcd_pkg::SQRT_STEPS;
    localparam int NSTAGE = DS + 2 * CORDIC_STEPS + SQ + 8;

    logic [NSTAGE-1:0] vld_reg;
    logic              adv;
    logic [23:0]       radius_reg;

    gcd_pkg::div_lane_t  d_reg  [DS+1][gcd_pkg::LANES];
    gcd_pkg::rot_lane_t  c_reg  [CORDIC_STEPS+1][gcd_pkg::LANES];
    gcd_pkg::sqrt_lane_t sq_reg [SQ+1][2];
    gcd_pkg::vec_lane_t  t_reg  [CORDIC_STEPS+1];

    logic signed [33:0] p_dlat_reg, p_dlon_reg, p_cc_reg;
    logic signed [33:0] p1_reg, p4_reg;
    logic [31:0]        rad_reg;
    logic [25:0]        dist_reg;

    assign adv       = !(vld_reg[NSTAGE-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[NSTAGE-1];
    assign distance_q8 = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= gcd_pkg::RADIUS_RESET;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
            end
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
        end
    end

    function automatic gcd_pkg::div_lane_t load_lane(input logic signed [30:0] v,
                                                     input logic full);
        gcd_pkg::div_lane_t l;
        logic [30:0] mag;
        mag   = v[30] ? 31'(-v) : 31'(v);
        l.neg = v[30];
        l.rem = '0;
        l.num = full ? (40'({mag, 9'b0}) + gcd_pkg::ROUND_BIAS)
                     : (40'({mag, 8'b0}) + gcd_pkg::ROUND_BIAS);
        return l;
    endfunction

    gcd_pkg::div_lane_t d_next [gcd_pkg::LANES];

    always_comb
    begin
        logic signed [30:0] dlat, dlon;
        dlat = 31'(lat_second) - 31'(lat_first);
        dlon = 31'(lon_second) - 31'(lon_first);
        d_next[0] = load_lane(dlat, 1'b0);
        d_next[1] = load_lane(dlon, 1'b0);
        d_next[2] = load_lane(31'(lat_first), 1'b1);
        d_next[3] = load_lane(31'(lat_second), 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0] <= d_next;
        end
    end

    for (genvar gk = 0; gk < DS; gk++)
    begin : g_div
        gcd_pkg::div_lane_t s_next [gcd_pkg::LANES];

        always_comb
        begin
            logic [6:0] r;
            for (int l = 0; l < gcd_pkg::LANES; l++)
            begin
                s_next[l] = d_reg[gk][l];
                for (int b = 0; b < gcd_pkg::DIV_BITS; b++)
                begin
                    r = {s_next[l].rem, s_next[l].num[39]};
                    if (r >= gcd_pkg::DEG_DIVISOR)
                    begin
                        r = r - gcd_pkg::DEG_DIVISOR;
                        s_next[l].num = {s_next[l].num[38:0], 1'b1};
                    end
                    else
                    begin
                        s_next[l].num = {s_next[l].num[38:0], 1'b0};
                    end
                    s_next[l].rem = r[5:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[gk+1] <= s_next;
            end
        end
    end

    gcd_pkg::rot_lane_t c_next [gcd_pkg::LANES];

    always_comb
    begin
        logic [31:0] bam;
        for (int l = 0; l < gcd_pkg::LANES; l++)
        begin
            bam = d_reg[DS][l].neg ? 32'(-d_reg[DS][l].num[31:0]) : d_reg[DS][l].num[31:0];
            c_next[l].quad = bam[31:30];
            c_next[l].z    = $signed({4'b0, bam[29:0]});
            c_next[l].x    = gcd_pkg::CORDIC_GAIN;
            c_next[l].y    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg[0] <= c_next;
        end
    end

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++)
    begin : g_rot
        gcd_pkg::rot_lane_t r_next [gcd_pkg::LANES];

        always_comb
        begin
            logic signed [33:0] dx, dy, at;
            at = $signed({4'b0, gcd_pkg::atan_bam(5'(gi))});
            for (int l = 0; l < gcd_pkg::LANES; l++)
            begin
                dx = c_reg[gi][l].y >>> gi;
                dy = c_reg[gi][l].x >>> gi;
                r_next[l] = c_reg[gi][l];
                if (!c_reg[gi][l].z[33])
                begin
                    r_next[l].x = c_reg[gi][l].x - dx;
                    r_next[l].y = c_reg[gi][l].y + dy;
                    r_next[l].z = c_reg[gi][l].z - at;
                end
                else
                begin
                    r_next[l].x = c_reg[gi][l].x + dx;
                    r_next[l].y = c_reg[gi][l].y - dy;
                    r_next[l].z = c_reg[gi][l].z + at;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_reg[gi+1] <= r_next;
            end
        end
    end

    function automatic logic signed [33:0] sin_of(input gcd_pkg::rot_lane_t l);
        logic signed [33:0] s;
        case (l.quad)
            2'd0:    s = l.y;
            2'd1:    s = l.x;
            2'd2:    s = -l.y;
            default: s = -l.x;
        endcase
        return s;
    endfunction

    function automatic logic signed [33:0] cos_of(input gcd_pkg::rot_lane_t l);
        logic signed [33:0] c;
        case (l.quad)
            2'd0:    c = l.x;
            2'd1:    c = -l.y;
            2'd2:    c = -l.x;
            default: c = l.y;
        endcase
        return c;
    endfunction

    function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                   input logic signed [33:0] b);
        logic signed [67:0] p;
        p = a * b;
        return p[63:30];
    endfunction

    logic signed [33:0] s_dlat, s_dlon, c_lat1, c_lat2;

    assign s_dlat = sin_of(c_reg[CORDIC_STEPS][0]);
    assign s_dlon = sin_of(c_reg[CORDIC_STEPS][1]);
    assign c_lat1 = cos_of(c_reg[CORDIC_STEPS][2]);
    assign c_lat2 = cos_of(c_reg[CORDIC_STEPS][3]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_dlat_reg <= mul_q30(s_dlat, s_dlat);
            p_dlon_reg <= mul_q30(s_dlon, s_dlon);
            p_cc_reg   <= mul_q30(c_lat1, c_lat2);
            p1_reg     <= p_dlat_reg;
            p4_reg     <= mul_q30(p_cc_reg, p_dlon_reg);
        end
    end

    gcd_pkg::sqrt_lane_t sq_next [2];

    always_comb
    begin
        logic signed [33:0] a;
        logic [30:0] ac, bc;
        a = p1_reg + p4_reg;
        if (a[33])
        begin
            ac = '0;
        end
        else if (a > gcd_pkg::ONE_Q30)
        begin
            ac = gcd_pkg::ONE_Q30[30:0];
        end
        else
        begin
            ac = a[30:0];
        end
        bc = gcd_pkg::ONE_Q30[30:0] - ac;
        sq_next[0].arg  = {1'b0, ac, 30'b0};
        sq_next[0].rem  = '0;
        sq_next[0].root = '0;
        sq_next[1].arg  = {1'b0, bc, 30'b0};
        sq_next[1].rem  = '0;
        sq_next[1].root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= sq_next;
        end
    end

    for (genvar gs = 0; gs < SQ; gs++)
    begin : g_sqrt
        gcd_pkg::sqrt_lane_t q_next [2];

        always_comb
        begin
            logic [34:0] t, tr;
            for (int l = 0; l < 2; l++)
            begin
                t  = {sq_reg[gs][l].rem[32:0], sq_reg[gs][l].arg[61:60]};
                tr = {2'b0, sq_reg[gs][l].root, 2'b01};
                q_next[l].arg = {sq_reg[gs][l].arg[59:0], 2'b00};
                if (t >= tr)
                begin
                    q_next[l].rem  = t - tr;
                    q_next[l].root = {sq_reg[gs][l].root[29:0], 1'b1};
                end
                else
                begin
                    q_next[l].rem  = t;
                    q_next[l].root = {sq_reg[gs][l].root[29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[gs+1] <= q_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg[0].x <= $signed({3'b0, sq_reg[SQ][1].root});
            t_reg[0].y <= $signed({3'b0, sq_reg[SQ][0].root});
            t_reg[0].z <= '0;
        end
    end

    for (genvar gv = 0; gv < CORDIC_STEPS; gv++)
    begin : g_vec
        gcd_pkg::vec_lane_t v_next;

        always_comb
        begin
            logic signed [33:0] dx, dy, at;
            at = $signed({4'b0, gcd_pkg::atan_bam(5'(gv))});
            dx = t_reg[gv].y >>> gv;
            dy = t_reg[gv].x >>> gv;
            v_next = t_reg[gv];
            if (t_reg[gv].y > 0)
            begin
                v_next.x = t_reg[gv].x + dx;
                v_next.y = t_reg[gv].y - dy;
                v_next.z = t_reg[gv].z + at;
            end
            else if (t_reg[gv].y < 0)
            begin
                v_next.x = t_reg[gv].x - dx;
                v_next.y = t_reg[gv].y + dy;
                v_next.z = t_reg[gv].z - at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                t_reg[gv+1] <= v_next;
            end
        end
    end

    logic [31:0] rad_next;
    logic [25:0] dist_next;

    always_comb
    begin
        logic [34:0] c2;
        logic [31:0] cang;
        logic [64:0] pr;
        if (t_reg[CORDIC_STEPS].z[33])
        begin
            c2 = '0;
        end
        else
        begin
            c2 = {t_reg[CORDIC_STEPS].z[33:0], 1'b0};
        end
        cang = (c2 > 35'(gcd_pkg::HALF_TURN)) ? gcd_pkg::HALF_TURN : c2[31:0];
        pr = 65'(cang) * 65'(gcd_pkg::TWO_PI_Q29) + 65'(gcd_pkg::HALF_TURN);
        rad_next = pr[63:32];
    end

    always_comb
    begin
        logic [56:0] pd;
        pd = 57'(radius_reg) * 57'(rad_reg) + (57'(1) << 28);
        dist_next = (pd[56:29] > 28'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX[25:0]
                                                          : pd[54:29];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg  <= rad_next;
            dist_reg <= dist_next;
        end
    end

endmodule
